// ----- rtl/core/nbge_pkg.sv -----
// Package for the n-body gravity Euler step block.
// Holds item, result and body record types, register indexes and FSM states.
// No dependencies.
package nbge_pkg;

    localparam int ALU_W = 106;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    localparam logic [1:0] REG_G_CONST    = 2'd0;
    localparam logic [1:0] REG_TIME_STEP  = 2'd1;
    localparam logic [1:0] REG_BODY_COUNT = 2'd2;

    typedef struct packed {
        logic               kind;
        logic [3:0]         body_index;
        logic [31:0]        mass;
        logic               is_fixed;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } cmd_t;

    typedef struct packed {
        logic [3:0]         out_index;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [31:0]        mass;
        logic               fixed;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } body_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_I,
        S_LD_I,
        S_RD_J,
        S_LD_J,
        S_SQX,
        S_SQY,
        S_SQRT,
        S_GM,
        S_NUM,
        S_DIVK,
        S_DIVU,
        S_KU,
        S_WB_I,
        S_RD_P,
        S_LD_P,
        S_MVX,
        S_MVY
    } state_t;

endpackage

// ----- rtl/core/nbody_gravity_euler_step.sv -----
// Top level of the n-body gravity Euler step block.
// Body table, sequencer and one shared bit-serial adder/subtractor.
// Depends on nbge_pkg.
//
// A load item writes one body slot. A step item runs all
// ordered pairs on one shared 106-bit add/subtract unit that retires one bit
// (two for the root) per cycle. Each pair takes two 33-step squares, a
// 33-step root, 32- and 25-step products for G*m*dt, a 105-step division,
// two 64-step divisions and two 32-step products; each body is then moved
// with two 25-step products. Fixed bodies skip their pair work.
// busy is high for the whole step. Results come out one per body, each on
// result and marked by done, which is high for a single cycle; the receiver cannot stall them.
module nbody_gravity_euler_step #(
    parameter int MAX_BODIES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  nbge_pkg::cmd_t   cmd,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    output logic             done,
    output nbge_pkg::result_t result
);

    localparam int W  = nbge_pkg::ALU_W;
    localparam int IW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CW = $clog2(MAX_BODIES + 1);

    function automatic logic signed [31:0] clamp32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -35'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    nbge_pkg::state_t state_reg, state_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, p_reg, p_next, n_reg, n_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic          axis_reg, axis_next;
    logic          done_reg, done_next;
    logic [31:0]   g_reg;
    logic [24:0]   ts_reg;
    logic [4:0]    bc_reg;

    logic [W-1:0]  acc_reg, acc_next, sh_reg, sh_next, q_reg, q_next;
    nbge_pkg::body_t rec_reg, rec_next;
    logic [32:0]   ax_reg, ax_next, ay_reg, ay_next;
    logic          sx_reg, sx_next, sy_reg, sy_next;
    logic [31:0]   mass_reg, mass_next;
    logic [65:0]   d2_reg, d2_next;
    logic [32:0]   d_reg, d_next;
    logic [63:0]   k_reg, k_next;
    nbge_pkg::result_t result_reg, result_next;

    nbge_pkg::body_t mem [MAX_BODIES];
    nbge_pkg::body_t rd_reg;
    logic            mem_we;
    logic [IW-1:0]   mem_waddr, rd_addr;
    nbge_pkg::body_t mem_wdata;

    logic [W-1:0]  alu_a, alu_b;
    logic          alu_sub;
    logic [W:0]    alu_res;
    logic          alu_ge;

    logic [7:0]    load_idx, bc_ext, n_ext;
    logic [CW-1:0] i_inc, j_inc, p_inc;
    logic signed [32:0] rx, ry;
    logic          k_cap, p_cap;
    logic [32:0]   dv_mag, mv_mag;
    logic signed [34:0] vsum, psum;
    logic signed [31:0] vsel, psel, vnew, pnew;
    logic          msign;
    logic [31:0]   vabs_x, vabs_y;

    assign alu_res = {1'b0, alu_a} + ({1'b0, alu_b} ^ {(W + 1){alu_sub}})
                   + (W + 1)'(alu_sub);
    assign alu_ge  = ~alu_res[W];

    assign load_idx = {4'b0, cmd.body_index};
    assign bc_ext   = {3'b0, bc_reg};
    assign n_ext    = (bc_ext > 8'(MAX_BODIES)) ? 8'(MAX_BODIES) : bc_ext;
    assign i_inc    = CW'(i_reg + 1'b1);
    assign j_inc    = CW'(j_reg + 1'b1);
    assign p_inc    = CW'(p_reg + 1'b1);

    assign rx = {rd_reg.pos_x[31], rd_reg.pos_x} - {rec_reg.pos_x[31], rec_reg.pos_x};
    assign ry = {rd_reg.pos_y[31], rd_reg.pos_y} - {rec_reg.pos_y[31], rec_reg.pos_y};

    assign k_cap  = (|q_reg[W-1:64]) || (q_reg[63] && (|q_reg[62:0]));
    assign p_cap  = (|acc_reg[95:64]) || (acc_reg[63] && (|acc_reg[62:31]));
    assign dv_mag = p_cap ? 33'h1_0000_0000 : acc_reg[63:31];
    assign vsel   = axis_reg ? rec_reg.vel_y : rec_reg.vel_x;
    assign msign  = axis_reg ? sy_reg : sx_reg;
    assign vsum   = msign ? (35'(vsel) - $signed({2'b0, dv_mag}))
                          : (35'(vsel) + $signed({2'b0, dv_mag}));
    assign vnew   = clamp32(vsum);

    assign mv_mag = acc_reg[56:24];
    assign psel   = (state_reg == nbge_pkg::S_MVY) ? rec_reg.pos_y : rec_reg.pos_x;
    assign psum   = sx_reg ? (35'(psel) - $signed({2'b0, mv_mag}))
                           : (35'(psel) + $signed({2'b0, mv_mag}));
    assign pnew   = clamp32(psum);

    assign vabs_x = rd_reg.vel_x[31] ? 32'(-rd_reg.vel_x) : rd_reg.vel_x;
    assign vabs_y = rec_reg.vel_y[31] ? 32'(-rec_reg.vel_y) : rec_reg.vel_y;

    assign busy   = (state_reg != nbge_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        p_next      = p_reg;
        n_next      = n_reg;
        cnt_next    = cnt_reg;
        axis_next   = axis_reg;
        done_next   = 1'b0;
        acc_next    = acc_reg;
        sh_next     = sh_reg;
        q_next      = q_reg;
        rec_next    = rec_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        mass_next   = mass_reg;
        d2_next     = d2_reg;
        d_next      = d_reg;
        k_next      = k_reg;
        result_next = result_reg;
        mem_we      = 1'b0;
        mem_waddr   = i_reg[IW-1:0];
        mem_wdata   = rec_reg;
        rd_addr     = i_reg[IW-1:0];
        alu_a       = '0;
        alu_b       = '0;
        alu_sub     = 1'b0;

        case (state_reg)
            nbge_pkg::S_SQX, nbge_pkg::S_SQY, nbge_pkg::S_GM, nbge_pkg::S_NUM,
            nbge_pkg::S_KU, nbge_pkg::S_MVX, nbge_pkg::S_MVY:
            begin
                alu_a = acc_reg;
                alu_b = q_reg[0] ? sh_reg : '0;
            end
            nbge_pkg::S_SQRT:
            begin
                alu_a   = {acc_reg[W-3:0], sh_reg[W-1:W-2]};
                alu_b   = {q_reg[W-3:0], 2'b01};
                alu_sub = 1'b1;
            end
            nbge_pkg::S_DIVK, nbge_pkg::S_DIVU:
            begin
                alu_a   = {acc_reg[W-2:0], sh_reg[W-1]};
                alu_b   = (state_reg == nbge_pkg::S_DIVK) ? W'(d2_reg) : W'(d_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
            end
        endcase

        case (state_reg)
            nbge_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.kind == nbge_pkg::KIND_LOAD)
                    begin
                        if (load_idx < 8'(MAX_BODIES))
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = load_idx[IW-1:0];
                            mem_wdata = '{mass: cmd.mass, fixed: cmd.is_fixed,
                                          pos_x: cmd.pos_x, pos_y: cmd.pos_y,
                                          vel_x: cmd.vel_x, vel_y: cmd.vel_y};
                        end
                    end
                    else if (n_ext != 8'd0)
                    begin
                        n_next     = n_ext[CW-1:0];
                        i_next     = '0;
                        state_next = nbge_pkg::S_RD_I;
                    end
                end
            end
            nbge_pkg::S_RD_I:
            begin
                rd_addr    = i_reg[IW-1:0];
                state_next = nbge_pkg::S_LD_I;
            end
            nbge_pkg::S_LD_I:
            begin
                rec_next = rd_reg;
                if (rd_reg.fixed)
                begin
                    i_next     = i_inc;
                    p_next     = '0;
                    state_next = (i_inc == n_reg) ? nbge_pkg::S_RD_P : nbge_pkg::S_RD_I;
                end
                else
                begin
                    j_next     = '0;
                    state_next = nbge_pkg::S_RD_J;
                end
            end
            nbge_pkg::S_RD_J:
            begin
                rd_addr = j_reg[IW-1:0];
                if (j_reg == i_reg)
                begin
                    j_next     = j_inc;
                    state_next = (j_inc == n_reg) ? nbge_pkg::S_WB_I : nbge_pkg::S_RD_J;
                end
                else
                    state_next = nbge_pkg::S_LD_J;
            end
            nbge_pkg::S_LD_J:
            begin
                if (rx == 33'sd0 && ry == 33'sd0)
                begin
                    j_next     = j_inc;
                    state_next = (j_inc == n_reg) ? nbge_pkg::S_WB_I : nbge_pkg::S_RD_J;
                end
                else
                begin
                    ax_next    = rx[32] ? 33'(-rx) : rx;
                    ay_next    = ry[32] ? 33'(-ry) : ry;
                    sx_next    = rx[32];
                    sy_next    = ry[32];
                    mass_next  = rd_reg.mass;
                    acc_next   = '0;
                    sh_next    = W'(rx[32] ? 33'(-rx) : rx);
                    q_next     = W'(rx[32] ? 33'(-rx) : rx);
                    cnt_next   = 7'd33;
                    state_next = nbge_pkg::S_SQX;
                end
            end
            nbge_pkg::S_SQX, nbge_pkg::S_SQY, nbge_pkg::S_GM, nbge_pkg::S_NUM,
            nbge_pkg::S_KU, nbge_pkg::S_MVX, nbge_pkg::S_MVY:
            begin
                if (cnt_reg != 7'd0)
                begin
                    acc_next = alu_res[W-1:0];
                    sh_next  = {sh_reg[W-2:0], 1'b0};
                    q_next   = {1'b0, q_reg[W-1:1]};
                    cnt_next = cnt_reg - 7'd1;
                end
                else
                begin
                    case (state_reg)
                        nbge_pkg::S_SQX:
                        begin
                            sh_next    = W'(ay_reg);
                            q_next     = W'(ay_reg);
                            cnt_next   = 7'd33;
                            state_next = nbge_pkg::S_SQY;
                        end
                        nbge_pkg::S_SQY:
                        begin
                            d2_next    = acc_reg[65:0];
                            acc_next   = '0;
                            q_next     = '0;
                            sh_next    = {acc_reg[65:0], (W - 66)'(0)};
                            cnt_next   = 7'd33;
                            state_next = nbge_pkg::S_SQRT;
                        end
                        nbge_pkg::S_GM:
                        begin
                            acc_next   = '0;
                            sh_next    = W'(acc_reg[63:0]);
                            q_next     = W'(ts_reg);
                            cnt_next   = 7'd25;
                            state_next = nbge_pkg::S_NUM;
                        end
                        nbge_pkg::S_NUM:
                        begin
                            acc_next   = '0;
                            q_next     = '0;
                            sh_next    = {acc_reg[88:0], 17'b0};
                            cnt_next   = 7'd105;
                            state_next = nbge_pkg::S_DIVK;
                        end
                        nbge_pkg::S_KU:
                        begin
                            if (axis_reg)
                                rec_next.vel_y = vnew;
                            else
                                rec_next.vel_x = vnew;
                            if (!axis_reg)
                            begin
                                axis_next  = 1'b1;
                                acc_next   = '0;
                                q_next     = '0;
                                sh_next    = {ay_reg, 31'b0, (W - 64)'(0)};
                                cnt_next   = 7'd64;
                                state_next = nbge_pkg::S_DIVU;
                            end
                            else
                            begin
                                j_next     = j_inc;
                                state_next = (j_inc == n_reg) ? nbge_pkg::S_WB_I
                                                              : nbge_pkg::S_RD_J;
                            end
                        end
                        nbge_pkg::S_MVX:
                        begin
                            rec_next.pos_x = pnew;
                            sx_next    = rec_reg.vel_y[31];
                            acc_next   = '0;
                            sh_next    = W'(vabs_y);
                            q_next     = W'(ts_reg);
                            cnt_next   = 7'd25;
                            state_next = nbge_pkg::S_MVY;
                        end
                        default:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = p_reg[IW-1:0];
                            mem_wdata  = rec_reg;
                            mem_wdata.pos_y = pnew;
                            result_next = '{out_index: 4'(p_reg), out_x: rec_reg.pos_x,
                                            out_y: pnew, last: (p_inc == n_reg)};
                            done_next  = 1'b1;
                            p_next     = p_inc;
                            state_next = (p_inc == n_reg) ? nbge_pkg::S_IDLE
                                                          : nbge_pkg::S_RD_P;
                        end
                    endcase
                end
            end
            nbge_pkg::S_SQRT:
            begin
                if (cnt_reg != 7'd0)
                begin
                    acc_next = alu_ge ? alu_res[W-1:0] : alu_a;
                    q_next   = {q_reg[W-2:0], alu_ge};
                    sh_next  = {sh_reg[W-3:0], 2'b00};
                    cnt_next = cnt_reg - 7'd1;
                end
                else
                begin
                    d_next     = q_reg[32:0];
                    acc_next   = '0;
                    sh_next    = W'(g_reg);
                    q_next     = W'(mass_reg);
                    cnt_next   = 7'd32;
                    state_next = nbge_pkg::S_GM;
                end
            end
            nbge_pkg::S_DIVK, nbge_pkg::S_DIVU:
            begin
                if (cnt_reg != 7'd0)
                begin
                    acc_next = alu_ge ? alu_res[W-1:0] : alu_a;
                    q_next   = {q_reg[W-2:0], alu_ge};
                    sh_next  = {sh_reg[W-2:0], 1'b0};
                    cnt_next = cnt_reg - 7'd1;
                end
                else if (state_reg == nbge_pkg::S_DIVK)
                begin
                    k_next     = k_cap ? 64'h8000_0000_0000_0000 : q_reg[63:0];
                    axis_next  = 1'b0;
                    acc_next   = '0;
                    q_next     = '0;
                    sh_next    = {ax_reg, 31'b0, (W - 64)'(0)};
                    cnt_next   = 7'd64;
                    state_next = nbge_pkg::S_DIVU;
                end
                else
                begin
                    acc_next   = '0;
                    sh_next    = W'(k_reg);
                    q_next     = W'(q_reg[31:0]);
                    cnt_next   = 7'd32;
                    state_next = nbge_pkg::S_KU;
                end
            end
            nbge_pkg::S_WB_I:
            begin
                mem_we     = 1'b1;
                mem_waddr  = i_reg[IW-1:0];
                mem_wdata  = rec_reg;
                i_next     = i_inc;
                p_next     = '0;
                state_next = (i_inc == n_reg) ? nbge_pkg::S_RD_P : nbge_pkg::S_RD_I;
            end
            nbge_pkg::S_RD_P:
            begin
                rd_addr    = p_reg[IW-1:0];
                state_next = nbge_pkg::S_LD_P;
            end
            nbge_pkg::S_LD_P:
            begin
                rec_next   = rd_reg;
                sx_next    = rd_reg.vel_x[31];
                acc_next   = '0;
                sh_next    = W'(vabs_x);
                q_next     = W'(ts_reg);
                cnt_next   = 7'd25;
                state_next = nbge_pkg::S_MVX;
            end
            default:
            begin
                state_next = nbge_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nbge_pkg::S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            p_reg     <= '0;
            n_reg     <= '0;
            cnt_reg   <= '0;
            axis_reg  <= 1'b0;
            done_reg  <= 1'b0;
            g_reg     <= 32'd65536;
            ts_reg    <= 25'd16777;
            bc_reg    <= 5'd2;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            p_reg     <= p_next;
            n_reg     <= n_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
            done_reg  <= done_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    nbge_pkg::REG_G_CONST:    g_reg  <= cfg_data;
                    nbge_pkg::REG_TIME_STEP:  ts_reg <= cfg_data[24:0];
                    nbge_pkg::REG_BODY_COUNT: bc_reg <= cfg_data[4:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        sh_reg     <= sh_next;
        q_reg      <= q_next;
        rec_reg    <= rec_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        mass_reg   <= mass_next;
        d2_reg     <= d2_next;
        d_reg      <= d_next;
        k_reg      <= k_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_reg <= mem[rd_addr];
    end

endmodule
